// ----- rtl/blid_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the bounded list block.
// No dependencies; imported by every module of the block.
package blid_pkg;

	// Command codes
	localparam logic [1:0] CMD_INS_FRONT = 2'd0;
	localparam logic [1:0] CMD_APPEND    = 2'd1;
	localparam logic [1:0] CMD_DELETE    = 2'd2;

	// Command word
	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] item_value;
		logic [5:0]         position;
	} in_word_t;

	// Dump word
	typedef struct packed {
		logic signed [31:0] entry_value;
		logic               last_entry;
		logic               list_empty;
		logic               insert_dropped;
	} out_word_t;

	// What one cell loads in a cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_TAKE_PREV,
		CELL_TAKE_NEXT,
		CELL_TAKE_WORD,
		CELL_TAKE_HEAD
	} cell_op_t;

	// Sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} seq_state_t;

	// Status into the sequencer
	typedef struct packed {
		logic cmd_valid;
		logic slot_free;
		logic empty;
		logic at_last;
	} seq_status_t;

	// Controls out of the sequencer
	typedef struct packed {
		logic cmd_ready;
		logic emit;
		logic rotate;
	} seq_ctrl_t;

endpackage

// ----- rtl/bounded_list_insert_delete_dump.sv -----
`timescale 1ns / 1ps
// Top level of the bounded list: a chain of value cells, a sequencer and a dump register.
// Depends on blid_pkg, blid_cell and blid_seq.
//
// Usage:
//   Command channel (cmd_valid/cmd_ready/cmd_word): one word inserts at the
//   front, appends at the back, or deletes the entry at a position. The list
//   is updated at the edge that accepts the word.
//   Dump channel (dump_valid/dump_ready/dump_word): after every command the
//   list goes out front to back, one word per entry, last_entry on the final
//   one; an empty list gives a single word with list_empty set. A refused
//   insert on a full list flags insert_dropped on every word of its dump.
//   Timing: the dump walks the cell chain by rotation, one entry per cycle while
//   the output register is free; the first dump word is loaded from the dump
//   state entered on acceptance. A new command is taken once the last dump
//   word has been loaded into the output register.
//   A stalled dump_ready freezes the rotation; nothing is lost.
//   Reset (arst_n low) empties the list; cell contents need no clearing.
module bounded_list_insert_delete_dump #(
	parameter int CAPACITY = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  blid_pkg::in_word_t  cmd_word,
	output logic                dump_valid,
	input  logic                dump_ready,
	output blid_pkg::out_word_t dump_word
);
	import blid_pkg::*;

	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (LEN_W > 6) ? LEN_W : 6;

	logic [LEN_W-1:0]   length_q;
	logic [LEN_W-1:0]   cnt_q;
	logic               dropped_q;
	logic               dump_valid_q;
	out_word_t          dump_word_q;

	logic signed [31:0] cell_value [CAPACITY];
	cell_op_t           cell_op    [CAPACITY];

	seq_status_t        status;
	seq_ctrl_t          ctrl;
	logic               accept;
	logic               full;
	logic               is_insert;
	logic               del_ok;
	logic [LEN_W-1:0]   last_idx;

	assign accept    = cmd_valid && ctrl.cmd_ready;
	assign full      = (length_q == LEN_W'(CAPACITY));
	assign is_insert = (cmd_word.cmd == CMD_INS_FRONT) || (cmd_word.cmd == CMD_APPEND);
	assign del_ok    = (cmd_word.cmd == CMD_DELETE) &&
		(CMP_W'(cmd_word.position) < CMP_W'(length_q));
	assign last_idx  = length_q - LEN_W'(1);

	// Sequencer
	assign status.cmd_valid = cmd_valid;
	assign status.slot_free = !dump_valid_q || dump_ready;
	assign status.empty     = (length_q == '0);
	assign status.at_last   = (cnt_q == last_idx);

	blid_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign cmd_ready = ctrl.cmd_ready;

	// Pick each cell's load: command update on accept, rotation during dump
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_op[i] = CELL_HOLD;
			if (accept) begin
				if (is_insert && !full) begin
					if (cmd_word.cmd == CMD_INS_FRONT) begin
						cell_op[i] = (i == 0) ? CELL_TAKE_WORD : CELL_TAKE_PREV;
					end else if (LEN_W'(i) == length_q) begin
						cell_op[i] = CELL_TAKE_WORD;
					end
				end else if (del_ok && (CMP_W'(i) >= CMP_W'(cmd_word.position))) begin
					cell_op[i] = CELL_TAKE_NEXT;
				end
			end else if (ctrl.rotate) begin
				if (LEN_W'(i) == last_idx) begin
					cell_op[i] = CELL_TAKE_HEAD;
				end else if (LEN_W'(i) < last_idx) begin
					cell_op[i] = CELL_TAKE_NEXT;
				end
			end
		end
	end

	// Cell chain
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		blid_cell u_cell (
			.clk        (clk),
			.op         (cell_op[g]),
			.prev_value (cell_value[(g == 0) ? 0 : g - 1]),
			.next_value (cell_value[(g == CAPACITY - 1) ? g : g + 1]),
			.word_value (cmd_word.item_value),
			.head_value (cell_value[0]),
			.value      (cell_value[g])
		);
	end

	// Track length, drop flag and dump position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q  <= '0;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			cnt_q     <= '0;
			dropped_q <= is_insert && full;
			if (is_insert && !full) begin
				length_q <= length_q + LEN_W'(1);
			end else if (del_ok) begin
				length_q <= length_q - LEN_W'(1);
			end
		end else if (ctrl.rotate) begin
			cnt_q <= cnt_q + LEN_W'(1);
		end
	end

	// Dump output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dump_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			dump_valid_q <= 1'b1;
		end else if (dump_ready) begin
			dump_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			dump_word_q.entry_value    <= status.empty ? 32'sd0 : cell_value[0];
			dump_word_q.last_entry     <= status.empty || status.at_last;
			dump_word_q.list_empty     <= status.empty;
			dump_word_q.insert_dropped <= dropped_q;
		end
	end

	assign dump_valid = dump_valid_q;
	assign dump_word  = dump_word_q;

`ifndef SYNTHESIS
	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= LEN_W'(CAPACITY))
		else $error("list length beyond capacity");

	a_length_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (length_q == $past(length_q)) ||
			(length_q == $past(length_q) + LEN_W'(1)) ||
			(length_q == $past(length_q) - LEN_W'(1)))
		else $error("length moved by more than one entry");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rotate |-> (cnt_q < length_q))
		else $error("dump position beyond length");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dump_valid && dump_word.list_empty) |-> dump_word.last_entry)
		else $error("empty dump word not marked last");
`endif

endmodule

// ----- rtl/blid_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the list chain: a 32-bit value register and its load mux.
// Depends on blid_pkg for the cell operation type.
module blid_cell (
	input  logic               clk,
	input  blid_pkg::cell_op_t op,
	input  logic signed [31:0] prev_value,
	input  logic signed [31:0] next_value,
	input  logic signed [31:0] word_value,
	input  logic signed [31:0] head_value,
	output logic signed [31:0] value
);
	import blid_pkg::*;

	logic signed [31:0] value_q;

	// Load from a neighbor, the command word or the head, or hold
	always_ff @(posedge clk) begin
		case (op)
			CELL_TAKE_PREV: value_q <= prev_value;
			CELL_TAKE_NEXT: value_q <= next_value;
			CELL_TAKE_WORD: value_q <= word_value;
			CELL_TAKE_HEAD: value_q <= head_value;
			default:        value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

// ----- rtl/blid_seq.sv -----
`timescale 1ns / 1ps
// Sequencer for the bounded list: takes a command, then walks the dump.
// Depends on blid_pkg for the state, status and control types.
module blid_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  blid_pkg::seq_status_t status,
	output blid_pkg::seq_ctrl_t   ctrl
);
	import blid_pkg::*;

	seq_state_t state_q;
	seq_state_t state_next;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Advance on a command, return after the last word is loaded
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (status.cmd_valid) begin
					state_next = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (status.slot_free && (status.empty || status.at_last)) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Drive the handshake and the chain controls
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				ctrl.cmd_ready = 1'b1;
			end
			ST_DUMP: begin
				ctrl.emit   = status.slot_free;
				ctrl.rotate = status.slot_free && !status.empty;
			end
			default: ctrl = '0;
		endcase
	end

endmodule

// ----- tb/bounded_list_insert_delete_dump_test.sv -----
`timescale 1ns / 1ps
// Self-checking test of the bounded list: commands go in, every dump word is checked in order.
// Depends on blid_pkg and bounded_list_insert_delete_dump; a local list copy predicts the dumps.
module bounded_list_insert_delete_dump_test;
	import blid_pkg::*;

	localparam int LIST_CAP = 32;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int LONG_HOLD = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 40;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	in_word_t cmd_word;
	logic dump_valid;
	logic dump_ready;
	out_word_t dump_word;

	// Local copy of the list, front first, and the dump words it predicts
	logic signed [31:0] list_vals[$];
	out_word_t expected_dump[$];

	int error_count = 0;
	int cmd_count = 0;
	int dump_count = 0;
	int refused_count = 0;
	int out_of_range_count = 0;
	int empty_dump_count = 0;
	int peak_length = 0;

	// Idling controls shared with the receiver process
	bit tx_gaps_on = 1'b0;
	bit rx_stalls_on = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int stall_left = 0;

	bounded_list_insert_delete_dump #(
		.CAPACITY(LIST_CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_word(cmd_word),
		.dump_valid(dump_valid),
		.dump_ready(dump_ready),
		.dump_word(dump_word)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Apply one command to the local list and queue the dump it causes
	task automatic apply_command(input in_word_t w);
		out_word_t ow;
		logic dropped;
		begin
			dropped = 1'b0;
			case (w.cmd)
				CMD_INS_FRONT, CMD_APPEND: begin
					if (list_vals.size() >= LIST_CAP) begin
						dropped = 1'b1;
						refused_count++;
					end else if (w.cmd == CMD_INS_FRONT) begin
						list_vals.push_front(w.item_value);
					end else begin
						list_vals.push_back(w.item_value);
					end
				end
				CMD_DELETE: begin
					if (w.position < list_vals.size())
						list_vals.delete(w.position);
					else
						out_of_range_count++;
				end
				default: ;
			endcase
			if (list_vals.size() > peak_length)
				peak_length = list_vals.size();
			if (list_vals.size() == 0) begin
				ow.entry_value = '0;
				ow.last_entry = 1'b1;
				ow.list_empty = 1'b1;
				ow.insert_dropped = dropped;
				expected_dump.push_back(ow);
				empty_dump_count++;
			end else begin
				for (int i = 0; i < list_vals.size(); i++) begin
					ow.entry_value = list_vals[i];
					ow.last_entry = (i == list_vals.size() - 1);
					ow.list_empty = 1'b0;
					ow.insert_dropped = dropped;
					expected_dump.push_back(ow);
				end
			end
		end
	endtask

	function automatic in_word_t make_word(input logic [1:0] c, input logic [31:0] v,
			input logic [5:0] p);
		in_word_t w;
		w.cmd = c;
		w.item_value = v;
		w.position = p;
		return w;
	endfunction

	// Mostly full-range values, with the extremes now and then
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 19))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Offer one command word, with an optional idle burst first; predict on acceptance
	task automatic send_word(input in_word_t w);
		int gap;
		begin
			gap = 0;
			if (tx_gaps_on && $urandom_range(0, 99) < 20)
				gap = $urandom_range(1, 16);
			@(negedge clk);
			if (gap > 0) begin
				cmd_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			cmd_valid = 1'b1;
			cmd_word = w;
			do @(posedge clk); while (!cmd_ready);
			apply_command(w);
			cmd_count++;
		end
	endtask

	task automatic release_cmd();
		@(negedge clk);
		cmd_valid = 1'b0;
	endtask

	task automatic wait_dump_done();
		while (expected_dump.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("ERROR at %0t: dump word %0d, %s: got %h, expected %h",
				$time, dump_count, what, got, want);
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		dump_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 99) < 8)
				stall_left = $urandom_range(1, 16);
			if (hold_left > 0) begin
				dump_ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				dump_ready = 1'b0;
				stall_left--;
			end else begin
				dump_ready = 1'b1;
			end
		end
	end

	// Check each accepted dump word against the oldest prediction
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && dump_valid && dump_ready) begin
			if (expected_dump.size() == 0) begin
				report_mismatch("unexpected word", dump_word.entry_value, '0);
			end else begin
				want = expected_dump.pop_front();
				if (dump_word.entry_value !== want.entry_value)
					report_mismatch("entry_value", dump_word.entry_value,
						want.entry_value);
				if (dump_word.last_entry !== want.last_entry)
					report_mismatch("last_entry", 32'(dump_word.last_entry),
						32'(want.last_entry));
				if (dump_word.list_empty !== want.list_empty)
					report_mismatch("list_empty", 32'(dump_word.list_empty),
						32'(want.list_empty));
				if (dump_word.insert_dropped !== want.insert_dropped)
					report_mismatch("insert_dropped", 32'(dump_word.insert_dropped),
						32'(want.insert_dropped));
			end
			dump_count++;
		end
	end

	// End the run if no word moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_ready) || (dump_valid && dump_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no handshake for %0d cycles, %0d dump words outstanding",
			STALL_LIMIT, expected_dump.size());
		$display("Simulation FAILED");
		$finish;
	end

	// Empty dumps, extremes, each command, out-of-range deletes, ignored fields
	task automatic test_directed();
		send_word(make_word(CMD_DELETE, 32'h1234_5678, 6'd0));
		send_word(make_word(CMD_UNUSED, 32'h7fff_ffff, 6'd63));
		send_word(make_word(CMD_INS_FRONT, 32'h8000_0000, 6'd0));
		send_word(make_word(CMD_APPEND, 32'h7fff_ffff, 6'd0));
		send_word(make_word(CMD_APPEND, 32'h0000_0000, 6'd63));
		send_word(make_word(CMD_INS_FRONT, 32'hffff_ffff, 6'd42));
		send_word(make_word(CMD_DELETE, 32'h5a5a_5a5a, 6'd63));
		send_word(make_word(CMD_DELETE, 32'ha5a5_a5a5, 6'd4));
		send_word(make_word(CMD_DELETE, 32'hffff_ffff, 6'd1));
		send_word(make_word(CMD_DELETE, 32'h0000_0000, 6'd2));
		send_word(make_word(CMD_UNUSED, 32'h8000_0000, 6'd21));
		send_word(make_word(CMD_DELETE, 32'h0000_0000, 6'd0));
		send_word(make_word(CMD_DELETE, 32'h0000_0000, 6'd0));
		send_word(make_word(CMD_APPEND, 32'h0000_0001, 6'd21));
		send_word(make_word(CMD_INS_FRONT, 32'hffff_fffe, 6'd42));
		send_word(make_word(CMD_DELETE, 32'hffff_ffff, 6'd1));
		send_word(make_word(CMD_DELETE, 32'h0000_0000, 6'd0));
	endtask

	// Fill to capacity, refuse inserts at both ends, then drain to empty
	task automatic test_fill_and_drop();
		while (list_vals.size() < LIST_CAP)
			send_word(make_word($urandom_range(0, 1) ? CMD_APPEND : CMD_INS_FRONT,
				pick_value(), 6'($urandom_range(0, 63))));
		send_word(make_word(CMD_INS_FRONT, pick_value(), 6'd0));
		send_word(make_word(CMD_APPEND, pick_value(), 6'd63));
		send_word(make_word(CMD_DELETE, pick_value(), 6'(LIST_CAP)));
		send_word(make_word(CMD_DELETE, pick_value(), 6'(LIST_CAP - 1)));
		send_word(make_word(CMD_INS_FRONT, pick_value(), 6'd0));
		send_word(make_word(CMD_APPEND, pick_value(), 6'd0));
		send_word(make_word(CMD_DELETE, pick_value(), 6'd0));
		while (list_vals.size() > 0)
			send_word(make_word(CMD_DELETE, pick_value(),
				6'($urandom_range(0, list_vals.size() - 1))));
	endtask

	// Hold the receiver off while commands keep coming, so the input stalls
	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++)
			send_word(make_word($urandom_range(0, 1) ? CMD_APPEND : CMD_INS_FRONT,
				pick_value(), 6'($urandom_range(0, 63))));
	endtask

	// Stop offering until every dump has come out, then resume
	task automatic test_sender_pause();
		for (int i = 0; i < 5; i++)
			send_word(make_word(CMD_APPEND, pick_value(), 6'($urandom_range(0, 63))));
		release_cmd();
		wait_dump_done();
		for (int i = 0; i < 5; i++)
			send_word(make_word(CMD_DELETE, pick_value(), 6'($urandom_range(0, 7))));
	endtask

	// Random commands in segments that lean toward growing or shrinking the list
	task automatic test_random_mix(input int n_items);
		int r;
		bit grow;
		logic [1:0] c;
		logic [5:0] p;
		begin
			grow = 1'b1;
			for (int i = 0; i < n_items; i++) begin
				if (i % 25 == 0)
					grow = 1'($urandom_range(0, 1));
				r = $urandom_range(0, 99);
				if (r < (grow ? 40 : 15))
					c = CMD_INS_FRONT;
				else if (r < (grow ? 80 : 30))
					c = CMD_APPEND;
				else if (r < 95)
					c = CMD_DELETE;
				else
					c = CMD_UNUSED;
				if (list_vals.size() > 0 && $urandom_range(0, 99) < 85)
					p = 6'($urandom_range(0, list_vals.size() - 1));
				else
					p = 6'($urandom_range(0, 63));
				send_word(make_word(c, pick_value(), p));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_word = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		test_directed();
		test_fill_and_drop();
		test_backpressure();
		test_sender_pause();
		test_random_mix(300);

		// Run the tail at full rate on both sides
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		test_random_mix(40);

		release_cmd();
		wait_dump_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_dump.size() != 0)
			report_mismatch("words never dumped", 32'(expected_dump.size()), 32'd0);

		$display("Ran %0d commands: %0d refused inserts, %0d out-of-range deletes.",
			cmd_count, refused_count, out_of_range_count);
		$display("Checked %0d dump words, %0d empty dumps, peak length %0d of %0d.",
			dump_count, empty_dump_count, peak_length, LIST_CAP);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
